@@ design/ntt_pkg.sv @@
// ----------------------------------------------------------------------------
// ntt_pkg
// Shared constants and types of the number theoretic transform block:
// modulus, roots of unity, field widths and multiplier handshake structs.
// ----------------------------------------------------------------------------
package ntt_pkg;

    // field widths
    localparam int VAL_W   = 30;
    localparam int POS_W   = 6;
    localparam int LOG_W   = 3;
    localparam int STAGE_W = 5;

    // default transform capacity (power of two)
    localparam int MAX_POINTS_DEF = 64;

    // modulus and root of unity of order 2^23, plus its inverse
    localparam logic [VAL_W-1:0] PRIME      = 30'd998244353;
    localparam logic [VAL_W-1:0] ROOT       = 30'd15311432;
    localparam logic [VAL_W-1:0] ROOT_INV   = 30'd469870224;
    localparam logic [STAGE_W-1:0] ROOT_LOG = 5'd23;

    // iterative multiplier: one operand bit per cycle
    localparam int MUL_CNT_W = 5;
    localparam logic [MUL_CNT_W-1:0] MUL_LAST = 5'd29;

    // configuration register indexes
    localparam logic CFG_LOG_LENGTH = 1'b0;
    localparam logic CFG_INVERSE    = 1'b1;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] product;
    } mul_rsp_t;

endpackage

@@ design/ntt_ram.sv @@
// ----------------------------------------------------------------------------
// ntt_ram
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module ntt_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/ntt_mulmod.sv @@
// ----------------------------------------------------------------------------
// ntt_mulmod
// Shared modular multiplier: double-and-add over the bits of b, one bit per
// cycle; done is raised once the last bit of b has been processed.
// ----------------------------------------------------------------------------
module ntt_mulmod (
    input  logic              clk,
    input  logic              rst_n,
    input  ntt_pkg::mul_req_t req,
    output ntt_pkg::mul_rsp_t rsp
);

    localparam logic [31:0] P1 = {2'b00, ntt_pkg::PRIME};
    localparam logic [31:0] P2 = {1'b0, ntt_pkg::PRIME, 1'b0};

    logic [ntt_pkg::VAL_W-1:0]     acc_reg;
    logic [ntt_pkg::VAL_W-1:0]     a_reg;
    logic [ntt_pkg::VAL_W-1:0]     b_reg;
    logic [ntt_pkg::MUL_CNT_W-1:0] cnt_reg;
    logic                          run_reg;
    logic                          done_reg;
    logic [31:0]                   sum;
    logic [31:0]                   red;

    // one double-and-add step, sum stays below three times the prime
    always_comb
    begin
        sum = {1'b0, acc_reg, 1'b0}
            + (b_reg[ntt_pkg::VAL_W-1] ? {2'b00, a_reg} : 32'd0);
        if (sum >= P2)
        begin
            red = sum - P2;
        end
        else if (sum >= P1)
        begin
            red = sum - P1;
        end
        else
        begin
            red = sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                acc_reg <= '0;
                a_reg   <= req.a;
                b_reg   <= req.b;
                cnt_reg <= '0;
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                acc_reg <= red[ntt_pkg::VAL_W-1:0];
                b_reg   <= {b_reg[ntt_pkg::VAL_W-2:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ntt_pkg::MUL_LAST)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

    // a new request never lands on a running multiply
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !run_reg)
        else $error("multiply request while busy");

endmodule

@@ design/number_theoretic_transform.sv @@
// ----------------------------------------------------------------------------
// number_theoretic_transform
// Radix-2 NTT modulo 998244353 of up to MAX_POINTS entries, forward or
// inverse, built around one shared iterative modular multiplier.
// ----------------------------------------------------------------------------
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  request   | start, busy, coefficient, frame_end       | in, busy out
//  result    | result_valid, value, position, final_value| out
//  config    | cfg_write, cfg_index, cfg_data            | in
//
// A request is taken when start is high and busy is low: one coefficient per
// cycle. frame_end raises busy for the whole transform: a bit-reversed copy,
// per stage s a twiddle from 23-s squarings of the root, and per butterfly
// two multiplies on the shared unit (one for the last butterfly of a group,
// which skips the twiddle update), then the results in order, each scaled by
// the inverse of n in inverse mode. Results come one per strobe
// and cannot be stalled. Reset is asynchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module number_theoretic_transform #(
    parameter int MAX_POINTS = ntt_pkg::MAX_POINTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [ntt_pkg::VAL_W-1:0]   coefficient,
    input  logic                        frame_end,
    output logic                        result_valid,
    output logic [ntt_pkg::VAL_W-1:0]   value,
    output logic [ntt_pkg::POS_W-1:0]   position,
    output logic                        final_value,
    input  logic                        cfg_write,
    input  logic                        cfg_index,
    input  logic [ntt_pkg::LOG_W-1:0]   cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = AW + 1;
    localparam int SW = ntt_pkg::STAGE_W;
    localparam int VW = ntt_pkg::VAL_W;

    typedef enum logic [3:0] {
        S_IDLE, S_COPY_RD, S_COPY_WR, S_STAGE, S_TW_START, S_TW_WAIT,
        S_BF_RD_B, S_BF_RD_A, S_BF_MUL, S_BF_WAIT, S_BF_WR_A, S_BF_WR_B,
        S_W_WAIT, S_EM_RD, S_EM_GET, S_EM_WAIT
    } state_t;

    state_t                    state_reg;
    logic [ntt_pkg::LOG_W-1:0] log_length_reg;
    logic                      inverse_reg;
    logic [CW-1:0]             load_count_reg;
    logic [SW-1:0]             nlog_reg;
    logic                      inv_reg;
    logic [CW-1:0]             i_reg;
    logic [CW-1:0]             k_reg;
    logic [CW-1:0]             grp_reg;
    logic [CW-1:0]             half_reg;
    logic [SW-1:0]             stage_reg;
    logic [SW-1:0]             sq_cnt_reg;
    logic                      hit_reg;
    logic [VW-1:0]             x_reg;
    logic [VW-1:0]             wlen_reg;
    logic [VW-1:0]             w_reg;
    logic [VW-1:0]             u_reg;
    logic [VW-1:0]             v_reg;
    logic                      result_valid_reg;
    logic [VW-1:0]             value_reg;
    logic [ntt_pkg::POS_W-1:0] position_reg;
    logic                      final_reg;

    logic [SW-1:0]   nlog_cur;
    logic [CW-1:0]   n_cur;
    logic [CW-1:0]   n_frame;
    logic [VW-1:0]   coef_red;
    logic [AW-1:0]   rev_idx;
    logic [AW-1:0]   addr_a;
    logic [AW-1:0]   addr_b;
    logic [VW:0]     bf_sum;
    logic [VW:0]     bf_diff;
    logic [VW-1:0]   ninv;
    logic [CW-1:0]   i_inc;
    logic [CW-1:0]   k_inc;
    logic [CW-1:0]   grp_nxt;

    logic            st_we;
    logic [AW-1:0]   st_waddr;
    logic [AW-1:0]   st_raddr;
    logic [VW-1:0]   st_rdata;
    logic            wk_we;
    logic [AW-1:0]   wk_waddr;
    logic [VW-1:0]   wk_wdata;
    logic [AW-1:0]   wk_raddr;
    logic [VW-1:0]   wk_rdata;

    ntt_pkg::mul_req_t mul_req;
    ntt_pkg::mul_rsp_t mul_rsp;

    // index reversed over the low nlog bits
    function automatic logic [AW-1:0] bit_rev(input logic [AW-1:0] idx,
                                              input logic [SW-1:0] nl);
        logic [AW-1:0] r;
        for (int b = 0; b < AW; b++)
        begin
            r[b] = idx[AW-1-b];
        end
        return r >> (SW'(AW) - nl);
    endfunction

    // length in force now and for the current frame
    always_comb
    begin
        if ({2'b00, log_length_reg} > SW'(AW))
        begin
            nlog_cur = SW'(AW);
        end
        else
        begin
            nlog_cur = {2'b00, log_length_reg};
        end
    end

    assign n_cur    = CW'(1) << nlog_cur;
    assign n_frame  = CW'(1) << nlog_reg;
    assign coef_red = (coefficient >= ntt_pkg::PRIME) ?
                      coefficient - ntt_pkg::PRIME : coefficient;
    assign rev_idx  = bit_rev(i_reg[AW-1:0], nlog_reg);
    assign addr_a   = grp_reg[AW-1:0] + k_reg[AW-1:0];
    assign addr_b   = addr_a + half_reg[AW-1:0];
    assign i_inc    = i_reg + 1'b1;
    assign k_inc    = k_reg + 1'b1;
    assign grp_nxt  = grp_reg + {half_reg[CW-2:0], 1'b0};
    assign ninv     = ntt_pkg::PRIME - ((ntt_pkg::PRIME - 1'b1) >> nlog_reg);

    // butterfly add and subtract modulo the prime
    always_comb
    begin
        bf_sum = {1'b0, u_reg} + {1'b0, mul_rsp.product};
        if (bf_sum >= {1'b0, ntt_pkg::PRIME})
        begin
            bf_sum = bf_sum - {1'b0, ntt_pkg::PRIME};
        end
        if (u_reg >= mul_rsp.product)
        begin
            bf_diff = {1'b0, u_reg} - {1'b0, mul_rsp.product};
        end
        else
        begin
            bf_diff = {1'b0, u_reg} + {1'b0, ntt_pkg::PRIME}
                    - {1'b0, mul_rsp.product};
        end
    end

    // memory and multiplier controls
    always_comb
    begin
        st_we      = 1'b0;
        st_waddr   = load_count_reg[AW-1:0];
        st_raddr   = rev_idx;
        wk_we      = 1'b0;
        wk_waddr   = i_reg[AW-1:0];
        wk_wdata   = hit_reg ? st_rdata : '0;
        wk_raddr   = i_reg[AW-1:0];
        mul_req    = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                st_we = start && (load_count_reg < n_cur);
            end
            S_COPY_WR:
            begin
                wk_we = 1'b1;
            end
            S_TW_START:
            begin
                mul_req.start = (sq_cnt_reg != '0);
                mul_req.a     = x_reg;
                mul_req.b     = x_reg;
            end
            S_BF_RD_B:
            begin
                wk_raddr = addr_b;
            end
            S_BF_RD_A:
            begin
                wk_raddr = addr_a;
            end
            S_BF_MUL:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = v_reg;
                mul_req.b     = w_reg;
            end
            S_BF_WR_A:
            begin
                wk_we    = 1'b1;
                wk_waddr = addr_a;
                wk_wdata = bf_sum[VW-1:0];
            end
            S_BF_WR_B:
            begin
                wk_we         = 1'b1;
                wk_waddr      = addr_b;
                wk_wdata      = bf_diff[VW-1:0];
                mul_req.start = (k_inc < half_reg);
                mul_req.a     = w_reg;
                mul_req.b     = wlen_reg;
            end
            S_EM_GET:
            begin
                mul_req.start = inv_reg;
                mul_req.a     = wk_rdata;
                mul_req.b     = ninv;
            end
            default:
            begin
            end
        endcase
    end

    // sequencer, configuration and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            log_length_reg   <= 3'd6;
            inverse_reg      <= 1'b0;
            load_count_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    ntt_pkg::CFG_LOG_LENGTH: log_length_reg <= cfg_data;
                    ntt_pkg::CFG_INVERSE:    inverse_reg    <= cfg_data[0];
                    default:                 inverse_reg    <= inverse_reg;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        if (load_count_reg < n_cur)
                        begin
                            load_count_reg <= load_count_reg + 1'b1;
                        end
                        if (frame_end)
                        begin
                            nlog_reg  <= nlog_cur;
                            inv_reg   <= inverse_reg;
                            i_reg     <= '0;
                            state_reg <= S_COPY_RD;
                        end
                    end
                end
                S_COPY_RD:
                begin
                    hit_reg   <= ({1'b0, rev_idx} < load_count_reg);
                    state_reg <= S_COPY_WR;
                end
                S_COPY_WR:
                begin
                    if (i_inc == n_frame)
                    begin
                        load_count_reg <= '0;
                        stage_reg      <= SW'(1);
                        half_reg       <= CW'(1);
                        state_reg      <= S_STAGE;
                    end
                    else
                    begin
                        i_reg     <= i_inc;
                        state_reg <= S_COPY_RD;
                    end
                end
                S_STAGE:
                begin
                    if (stage_reg > nlog_reg)
                    begin
                        i_reg     <= '0;
                        state_reg <= S_EM_RD;
                    end
                    else
                    begin
                        x_reg      <= inv_reg ? ntt_pkg::ROOT_INV : ntt_pkg::ROOT;
                        sq_cnt_reg <= ntt_pkg::ROOT_LOG - stage_reg;
                        state_reg  <= S_TW_START;
                    end
                end
                S_TW_START:
                begin
                    if (sq_cnt_reg == '0)
                    begin
                        wlen_reg  <= x_reg;
                        w_reg     <= VW'(1);
                        grp_reg   <= '0;
                        k_reg     <= '0;
                        state_reg <= S_BF_RD_B;
                    end
                    else
                    begin
                        state_reg <= S_TW_WAIT;
                    end
                end
                S_TW_WAIT:
                begin
                    if (mul_rsp.done)
                    begin
                        x_reg      <= mul_rsp.product;
                        sq_cnt_reg <= sq_cnt_reg - 1'b1;
                        state_reg  <= S_TW_START;
                    end
                end
                S_BF_RD_B:
                begin
                    state_reg <= S_BF_RD_A;
                end
                S_BF_RD_A:
                begin
                    v_reg     <= wk_rdata;
                    state_reg <= S_BF_MUL;
                end
                S_BF_MUL:
                begin
                    u_reg     <= wk_rdata;
                    state_reg <= S_BF_WAIT;
                end
                S_BF_WAIT:
                begin
                    if (mul_rsp.done)
                    begin
                        state_reg <= S_BF_WR_A;
                    end
                end
                S_BF_WR_A:
                begin
                    state_reg <= S_BF_WR_B;
                end
                S_BF_WR_B:
                begin
                    if (k_inc < half_reg)
                    begin
                        k_reg     <= k_inc;
                        state_reg <= S_W_WAIT;
                    end
                    else
                    begin
                        k_reg <= '0;
                        w_reg <= VW'(1);
                        if (grp_nxt < n_frame)
                        begin
                            grp_reg   <= grp_nxt;
                            state_reg <= S_BF_RD_B;
                        end
                        else
                        begin
                            stage_reg <= stage_reg + 1'b1;
                            half_reg  <= {half_reg[CW-2:0], 1'b0};
                            state_reg <= S_STAGE;
                        end
                    end
                end
                S_W_WAIT:
                begin
                    if (mul_rsp.done)
                    begin
                        w_reg     <= mul_rsp.product;
                        state_reg <= S_BF_RD_B;
                    end
                end
                S_EM_RD:
                begin
                    state_reg <= S_EM_GET;
                end
                S_EM_GET:
                begin
                    if (inv_reg)
                    begin
                        state_reg <= S_EM_WAIT;
                    end
                    else
                    begin
                        result_valid_reg <= 1'b1;
                        value_reg        <= wk_rdata;
                        position_reg     <= ntt_pkg::POS_W'(i_reg);
                        final_reg        <= (i_inc == n_frame);
                        i_reg            <= i_inc;
                        state_reg        <= (i_inc == n_frame) ? S_IDLE : S_EM_RD;
                    end
                end
                S_EM_WAIT:
                begin
                    if (mul_rsp.done)
                    begin
                        result_valid_reg <= 1'b1;
                        value_reg        <= mul_rsp.product;
                        position_reg     <= ntt_pkg::POS_W'(i_reg);
                        final_reg        <= (i_inc == n_frame);
                        i_reg            <= i_inc;
                        state_reg        <= (i_inc == n_frame) ? S_IDLE : S_EM_RD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // coefficient store in load order, then working array for the butterflies
    ntt_ram #(.WIDTH(VW), .DEPTH(MAX_POINTS)) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (coef_red),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    ntt_ram #(.WIDTH(VW), .DEPTH(MAX_POINTS)) u_work (
        .clk   (clk),
        .we    (wk_we),
        .waddr (wk_waddr),
        .wdata (wk_wdata),
        .raddr (wk_raddr),
        .rdata (wk_rdata)
    );

    ntt_mulmod u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign value        = value_reg;
    assign position     = position_reg;
    assign final_value  = final_reg;

    // the last result of a frame frees the block, earlier ones keep it busy
    a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && final_value |-> !busy)
        else $error("busy after last result");

    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !final_value |-> busy)
        else $error("idle in the middle of a frame");

    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> value < ntt_pkg::PRIME)
        else $error("result not reduced");

    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        load_count_reg <= CW'(MAX_POINTS))
        else $error("load count past capacity");

endmodule
